[hw/rtl/http_chunked_decoder_defines.svh]
// Assertion helpers used by the decoder RTL.
`ifndef HTTP_CHUNKED_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("http_chunked_decoder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("http_chunked_decoder: next-cycle check failed");

`endif

[hw/rtl/hcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared constants, types and helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

    localparam int MAX_BODY = 1048576;
    // The size accumulator can reach MAX_BODY * 16 + 15 before it freezes.
    localparam int CHUNK_W  = $clog2(MAX_BODY * 16 + 16);
    localparam int COUNT_W  = 21;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [7:0]         CH_LF     = 8'h0A;
    localparam logic [7:0]         CH_CR     = 8'h0D;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               byte_valid;
        logic               end_of_body;
        logic [COUNT_W-1:0] decoded_length;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h41 + 8'd10);
        end
        return h;
    endfunction

endpackage

[hw/rtl/http_chunked_decoder.sv]
`timescale 1ns / 1ps
// Each result is registered in the output buffer before it reaches the output.
// Throughput: one byte per cycle while the input is not stalled.
// A one-entry skid buffer registers the input stall; it rises only when two
// results wait behind a stalled output.
// Reset: synchronous, active low; clears parse state, count and the buffer.
// ----------------------------------------------------------------------------
// http_chunked_decoder
// Streams a chunked HTTP body; passes on its payload bytes and end of body.
// ----------------------------------------------------------------------------
`include "http_chunked_decoder_defines.svh"

module http_chunked_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_in_last,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_data_byte,
    output logic                            o_byte_valid,
    output logic                            o_end_of_body,
    output logic [hcd_pkg::COUNT_W-1:0]     o_decoded_length
);

    logic             in_accept;
    logic             res_valid;
    hcd_pkg::t_result res;
    hcd_pkg::t_result out_res;

    assign in_accept = i_in_valid && !o_in_stall;

    hcd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (i_in_byte),
        .i_last      (i_in_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hcd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (out_res),
        .o_in_stall  (o_in_stall)
    );

    assign o_data_byte      = out_res.data_byte;
    assign o_byte_valid     = out_res.byte_valid;
    assign o_end_of_body    = out_res.end_of_body;
    assign o_decoded_length = out_res.decoded_length;

    // The skid entry is only ever filled behind a held output.
    `HCD_ASSERT_NOW(a_stall_has_output, i_clk, i_rst_n, o_in_stall, o_out_valid)
    // A transfer out while the skid entry is full frees the input next cycle.
    `HCD_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n,
        o_in_stall && o_out_valid && !i_out_stall, !o_in_stall)
    // Every result carries a payload byte or marks the end of the body.
    `HCD_ASSERT_NOW(a_result_reason, i_clk, i_rst_n, o_out_valid,
        o_byte_valid || o_end_of_body)
    // An end-only result carries a zero data byte.
    `HCD_ASSERT_NOW(a_idle_byte_zero, i_clk, i_rst_n, o_out_valid && !o_byte_valid,
        o_data_byte == 8'd0)

endmodule

[hw/rtl/hcd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_core
// Parse state of the decoder and its combinational update for one body byte.
// ----------------------------------------------------------------------------
module hcd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output logic                o_res_valid,
    output hcd_pkg::t_result    o_res
);

    typedef enum logic [2:0] {
        PH_SIZE = 3'd0,
        PH_SKIP = 3'd1,
        PH_DATA = 3'd2,
        PH_CR   = 3'd3,
        PH_LF   = 3'd4,
        PH_STOP = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase                       phase;
        logic [hcd_pkg::CHUNK_W-1:0]  chunk;
        logic                         saw;
    } t_line;

    t_phase                       r_phase, n_phase;
    logic [hcd_pkg::CHUNK_W-1:0]  r_chunk, n_chunk;
    logic                         r_saw, n_saw;
    logic [hcd_pkg::COUNT_W-1:0]  r_count, n_count;
    logic                         data_hit;
    t_line                        line_in, line_out, fresh_line;

    // One byte of a size line: hex digits first, then the rest up to LF.
    function automatic t_line size_byte(t_line cur, logic [7:0] c);
        t_line       res;
        hcd_pkg::t_hex h;
        res = cur;
        h   = hcd_pkg::hex_value(c);
        if (cur.phase == PH_SIZE && h.ok) begin
            if (cur.chunk <= hcd_pkg::CHUNK_W'(hcd_pkg::MAX_BODY)) begin
                res.chunk = {cur.chunk[hcd_pkg::CHUNK_W-5:0], h.val};
            end
            res.saw = 1'b1;
        end else begin
            res.phase = PH_SKIP;
            if (c == hcd_pkg::CH_LF) begin
                res.phase = (!cur.saw || cur.chunk == '0) ? PH_STOP : PH_DATA;
            end
        end
        return res;
    endfunction

    assign fresh_line = '{phase: PH_SIZE, chunk: '0, saw: 1'b0};
    assign line_in    = '{phase: r_phase, chunk: r_chunk, saw: r_saw};

    always_comb begin
        n_phase  = r_phase;
        n_chunk  = r_chunk;
        n_saw    = r_saw;
        n_count  = r_count;
        data_hit = 1'b0;
        line_out = line_in;
        unique case (r_phase)
            PH_SIZE, PH_SKIP: begin
                line_out = size_byte(line_in, i_byte);
                n_phase  = line_out.phase;
                n_chunk  = line_out.chunk;
                n_saw    = line_out.saw;
            end
            PH_DATA: begin
                data_hit = 1'b1;
                if (r_count != hcd_pkg::COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
                if (r_chunk != '0) begin
                    n_chunk = r_chunk - 1'b1;
                end
                if (r_chunk <= hcd_pkg::CHUNK_W'(1)) begin
                    n_phase = PH_CR;
                end
            end
            PH_CR, PH_LF: begin
                if (r_phase == PH_CR && i_byte == hcd_pkg::CH_CR) begin
                    line_out = '{phase: PH_LF, chunk: r_chunk, saw: r_saw};
                end else if (i_byte == hcd_pkg::CH_LF) begin
                    line_out = fresh_line;
                end else begin
                    line_out = size_byte(fresh_line, i_byte);
                end
                n_phase = line_out.phase;
                n_chunk = line_out.chunk;
                n_saw   = line_out.saw;
            end
            default: begin
                // Stopped, and the unused codes behave the same way.
            end
        endcase
    end

    assign o_res_valid          = i_accept && (data_hit || i_last);
    assign o_res.data_byte      = data_hit ? i_byte : 8'd0;
    assign o_res.byte_valid     = data_hit;
    assign o_res.end_of_body    = i_last;
    assign o_res.decoded_length = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_chunk <= '0;
            r_saw   <= 1'b0;
            r_count <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                // A new body starts with the next byte.
                r_phase <= PH_SIZE;
                r_chunk <= '0;
                r_saw   <= 1'b0;
                r_count <= '0;
            end else begin
                r_phase <= n_phase;
                r_chunk <= n_chunk;
                r_saw   <= n_saw;
                r_count <= n_count;
            end
        end
    end

endmodule

[hw/rtl/hcd_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_out_buf
// Output register with one skid entry, so the input stall is registered.
// ----------------------------------------------------------------------------
module hcd_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  hcd_pkg::t_result    i_res,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output hcd_pkg::t_result    o_res,
    output logic                o_in_stall
);

    logic             r_out_valid;
    logic             r_skid_valid;
    hcd_pkg::t_result r_out;
    hcd_pkg::t_result r_skid;
    logic             take;

    assign take        = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_in_stall  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // No new transfer comes in while the skid entry is occupied.
            if (take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (!r_out_valid || take) begin
                r_out       <= i_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
